@@ rtl/cnms_pkg.sv @@
// package: widths, constants and types for canny non-max suppression
package cnms_pkg;
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int GRAD_BITS_DEF = 12;
	localparam int CMD_PIXEL = 0;
	localparam int CMD_FLUSH = 1;
	localparam logic [16:0] TAN_LO_Q16 = 17'd27146;
	localparam logic [17:0] TAN_HI_Q16 = 18'd158218;
	localparam logic [10:0] WIDTH_RESET = 11'd640;
	localparam logic [15:0] HEIGHT_RESET = 16'd480;
	localparam logic CFG_WIDTH = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;
	localparam int MAG_OUT_BITS = 12;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		SEC_HORIZ = 2'd0,
		SEC_DIAG = 2'd1,
		SEC_VERT = 2'd2,
		SEC_ANTI = 2'd3
	} sector_t;
endpackage

@@ rtl/cnms_front.sv @@
// front part: sector and squared magnitude of each pixel
module cnms_front #(
	parameter int GRAD_BITS = cnms_pkg::GRAD_BITS_DEF,
	parameter int MAG_BITS = 2 * GRAD_BITS + 1
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic in_cmd,
	input logic signed [GRAD_BITS-1:0] in_gx,
	input logic signed [GRAD_BITS-1:0] in_gy,
	output logic out_valid,
	input logic out_ready,
	output logic out_cmd,
	output logic [MAG_BITS-1:0] out_mag,
	output cnms_pkg::sector_t out_sec
);
	localparam int AB = GRAD_BITS;
	logic valid_s1;
	logic cmd_s1;
	logic [AB-1:0] ax_s1, ay_s1;
	logic same_s1;
	logic [AB-1:0] ax, ay;
	logic [AB+17:0] ay_sh, lo_p, hi_p;
	logic [2*AB-1:0] ax2, ay2;

	assign in_ready = !valid_s1 || out_ready;
	assign ax = in_gx[GRAD_BITS-1] ? AB'(-in_gx) : AB'(in_gx);
	assign ay = in_gy[GRAD_BITS-1] ? AB'(-in_gy) : AB'(in_gy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1 <= in_cmd;
			ax_s1 <= ax;
			ay_s1 <= ay;
			same_s1 <= in_gx[GRAD_BITS-1] == in_gy[GRAD_BITS-1];
		end
	end

	assign ay_sh = {2'b00, ay_s1, 16'd0};
	assign lo_p = (AB+18)'(ax_s1) * (AB+18)'(cnms_pkg::TAN_LO_Q16);
	assign hi_p = (AB+18)'(ax_s1) * (AB+18)'(cnms_pkg::TAN_HI_Q16);
	assign ax2 = (2*AB)'(ax_s1) * (2*AB)'(ax_s1);
	assign ay2 = (2*AB)'(ay_s1) * (2*AB)'(ay_s1);

	always_comb begin
		if (ay_sh <= lo_p) out_sec = cnms_pkg::SEC_HORIZ;
		else if (ay_sh > hi_p) out_sec = cnms_pkg::SEC_VERT;
		else if (same_s1) out_sec = cnms_pkg::SEC_DIAG;
		else out_sec = cnms_pkg::SEC_ANTI;
	end

	assign out_valid = valid_s1;
	assign out_cmd = cmd_s1;
	assign out_mag = MAG_BITS'(ax2) + MAG_BITS'(ay2);
endmodule

@@ rtl/cnms_queue.sv @@
// short queue between front and back parts
module cnms_queue #(
	parameter int DW = 8,
	parameter int DEPTH = cnms_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [DW-1:0] in_data,
	output logic out_valid,
	input logic out_ready,
	output logic [DW-1:0] out_data
);
	localparam int AW = $clog2(DEPTH);
	logic [DW-1:0] mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic push, pop;

	assign in_ready = cnt_q != (AW+1)'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;
	assign out_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

@@ rtl/cnms_isqrt.sv @@
// iterative floor square root, one result bit per cycle
module cnms_isqrt #(
	parameter int MAG_BITS = 25
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [MAG_BITS-1:0] value,
	output logic busy,
	output logic [MAG_BITS/2:0] root
);
	localparam int RB = MAG_BITS / 2 + 1;
	localparam int VB = 2 * RB;
	localparam int CB = $clog2(RB + 1);
	logic [VB-1:0] v_q;
	logic [RB+1:0] rem_q;
	logic [RB-1:0] res_q;
	logic [CB-1:0] n_q;
	logic [RB+1:0] rem_n, trial;

	assign rem_n = {rem_q[RB-1:0], v_q[VB-1 -: 2]};
	assign trial = {res_q, 2'b01};
	assign busy = n_q != '0;
	assign root = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (start) begin
			n_q <= CB'(RB);
		end else if (busy) begin
			n_q <= n_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= VB'(value);
			rem_q <= '0;
			res_q <= '0;
		end else if (busy) begin
			v_q <= {v_q[VB-3:0], 2'b00};
			if (rem_n >= trial) begin
				rem_q <= rem_n - trial;
				res_q <= {res_q[RB-2:0], 1'b1};
			end else begin
				rem_q <= rem_n;
				res_q <= {res_q[RB-2:0], 1'b0};
			end
		end
	end
endmodule

@@ rtl/cnms_back.sv @@
// back part: line stores, counters, neighbour compares, square root and result register
module cnms_back #(
	parameter int MAX_WIDTH = cnms_pkg::MAX_WIDTH_DEF,
	parameter int MAG_BITS = 25
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr,
	input logic cfg_idx,
	input logic [15:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic in_cmd,
	input logic [MAG_BITS-1:0] in_mag,
	input cnms_pkg::sector_t in_sec,
	output logic out_valid,
	input logic out_ready,
	output logic [cnms_pkg::MAG_OUT_BITS-1:0] out_mag,
	output cnms_pkg::sector_t out_sec,
	output logic out_last
);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int MA = $clog2(3 * MAX_WIDTH);
	localparam int SA = $clog2(2 * MAX_WIDTH);
	localparam int RB = MAG_BITS / 2 + 1;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_RD_C = 7'b0000010,
		ST_RD_A = 7'b0000100,
		ST_RD_B = 7'b0001000,
		ST_CMP = 7'b0010000,
		ST_SQRT = 7'b0100000,
		ST_OUT = 7'b1000000
	} state_t;

	logic [MAG_BITS-1:0] mag_mem [3*MAX_WIDTH];
	logic [1:0] sec_mem [2*MAX_WIDTH];
	logic [10:0] width_q;
	logic [15:0] height_q;
	logic [15:0] irow_q, orow_q;
	logic [1:0] irow3_q, orow3_q;
	logic [CW-1:0] icol_q, ocol_q;
	logic [16+CW:0] gap_q;
	state_t st_q;
	logic [MAG_BITS-1:0] rd_q, cen_q;
	logic [1:0] srd_q;
	logic [MA-1:0] raddr;
	logic [CW:0] w_eff;
	logic [15:0] h_eff;
	logic draining;
	logic accept, emit_now;
	logic a_in, b_in, sup_q, sq_start, sq_busy;
	logic [RB-1:0] root;
	logic [CW:0] ac, bc;
	logic [16:0] ar, br;
	logic [1:0] ar3, br3;
	logic [CW-1:0] ocol_n;
	logic [15:0] orow_n;
	logic [1:0] orow3_n;
	logic owrap, ofin;

	always_comb begin
		if (width_q == '0) w_eff = (CW+1)'(1);
		else if (32'(width_q) > 32'(MAX_WIDTH)) w_eff = (CW+1)'(MAX_WIDTH);
		else w_eff = (CW+1)'(width_q);
		h_eff = (height_q == '0) ? 16'd1 : height_q;
	end

	assign draining = irow_q >= h_eff;
	assign in_ready = st_q == ST_IDLE;
	assign accept = in_valid && in_ready;
	assign emit_now = accept && (in_cmd ? draining :
		(!draining && gap_q + 1'b1 >= (17+CW)'(w_eff) + 2'd2));

	// neighbour coordinates
	always_comb begin
		a_in = 1'b1;
		b_in = 1'b1;
		ar = {1'b0, orow_q};
		br = {1'b0, orow_q};
		ar3 = orow3_q;
		br3 = orow3_q;
		ac = {1'b0, ocol_q};
		bc = {1'b0, ocol_q};
		case (cnms_pkg::sector_t'(srd_q))
			cnms_pkg::SEC_HORIZ: begin
				ac = ac + 1'b1;
				bc = bc - 1'b1;
			end
			cnms_pkg::SEC_DIAG: begin
				ac = ac + 1'b1;
				bc = bc - 1'b1;
				ar = ar + 1'b1;
				br = br - 1'b1;
			end
			cnms_pkg::SEC_VERT: begin
				ar = ar + 1'b1;
				br = br - 1'b1;
			end
			default: begin
				ac = ac + 1'b1;
				bc = bc - 1'b1;
				ar = ar - 1'b1;
				br = br + 1'b1;
			end
		endcase
		if (ar != {1'b0, orow_q}) begin
			ar3 = (ar > {1'b0, orow_q}) ? ((orow3_q == 2'd2) ? 2'd0 : orow3_q + 1'b1)
				: ((orow3_q == 2'd0) ? 2'd2 : orow3_q - 1'b1);
			br3 = (br > {1'b0, orow_q}) ? ((orow3_q == 2'd2) ? 2'd0 : orow3_q + 1'b1)
				: ((orow3_q == 2'd0) ? 2'd2 : orow3_q - 1'b1);
		end
		if (ar[16] || ar >= {1'b0, h_eff} || ac[CW] && ac >= w_eff || ac >= w_eff) a_in = 1'b0;
		if (br[16] || br >= {1'b0, h_eff} || bc >= w_eff) b_in = 1'b0;
	end

	always_comb begin
		case (st_q)
			ST_RD_A: raddr = MA'(ar3) * MA'(MAX_WIDTH) + MA'(ac[CW-1:0]);
			ST_RD_B: raddr = MA'(br3) * MA'(MAX_WIDTH) + MA'(bc[CW-1:0]);
			default: raddr = MA'(orow3_q) * MA'(MAX_WIDTH) + MA'(ocol_q);
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && in_cmd == 1'(cnms_pkg::CMD_PIXEL) && !draining) begin
			mag_mem[MA'(irow3_q) * MA'(MAX_WIDTH) + MA'(icol_q)] <= in_mag;
			sec_mem[SA'(irow_q[0]) * SA'(MAX_WIDTH) + SA'(icol_q)] <= in_sec;
		end
		rd_q <= mag_mem[raddr];
		srd_q <= sec_mem[SA'(orow_q[0]) * SA'(MAX_WIDTH) + SA'(ocol_q)];
	end

	assign ocol_n = ocol_q + 1'b1;
	assign owrap = (CW+1)'(ocol_n) >= w_eff || ocol_q == CW'(MAX_WIDTH - 1);
	assign orow_n = orow_q + 1'b1;
	assign orow3_n = (orow3_q == 2'd2) ? 2'd0 : orow3_q + 1'b1;
	assign ofin = owrap && orow_n >= h_eff;
	assign sq_start = st_q == ST_CMP;

	cnms_isqrt #(.MAG_BITS(MAG_BITS)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .value(cen_q),
		.busy(sq_busy), .root(root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= cnms_pkg::WIDTH_RESET;
			height_q <= cnms_pkg::HEIGHT_RESET;
			irow_q <= '0; irow3_q <= '0; icol_q <= '0;
			orow_q <= '0; orow3_q <= '0; ocol_q <= '0;
			gap_q <= '0;
			st_q <= ST_IDLE;
			out_valid <= 1'b0;
		end else if (cfg_wr) begin
			if (cfg_idx == cnms_pkg::CFG_WIDTH) width_q <= cfg_data[10:0];
			else height_q <= cfg_data;
			irow_q <= '0; irow3_q <= '0; icol_q <= '0;
			orow_q <= '0; orow3_q <= '0; ocol_q <= '0;
			gap_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (accept && in_cmd == 1'(cnms_pkg::CMD_PIXEL) && !draining) begin
						gap_q <= gap_q + 1'b1;
						if ((CW+1)'(icol_q) + 1'b1 >= w_eff) begin
							icol_q <= '0;
							irow_q <= irow_q + 1'b1;
							irow3_q <= (irow3_q == 2'd2) ? 2'd0 : irow3_q + 1'b1;
						end else begin
							icol_q <= icol_q + 1'b1;
						end
					end
					if (emit_now) st_q <= ST_RD_C;
				end
				ST_RD_C: st_q <= ST_RD_A;
				ST_RD_A: begin
					cen_q <= rd_q;
					st_q <= ST_RD_B;
				end
				ST_RD_B: begin
					sup_q <= a_in && rd_q > cen_q;
					st_q <= ST_CMP;
				end
				ST_CMP: begin
					if (a_in && b_in && rd_q > cen_q) sup_q <= 1'b1;
					st_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (!sq_busy && !out_valid) begin
						out_mag <= sup_q ? '0 : cnms_pkg::MAG_OUT_BITS'(root);
						out_sec <= cnms_pkg::sector_t'(srd_q);
						out_last <= ofin;
						out_valid <= 1'b1;
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					gap_q <= gap_q - 1'b1;
					if (ofin) begin
						irow_q <= '0; irow3_q <= '0; icol_q <= '0;
						orow_q <= '0; orow3_q <= '0; ocol_q <= '0;
						gap_q <= '0;
					end else if (owrap) begin
						ocol_q <= '0;
						orow_q <= orow_n;
						orow3_q <= orow3_n;
					end else begin
						ocol_q <= ocol_n;
					end
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
			if (out_valid && out_ready) out_valid <= 1'b0;
		end
	end
endmodule

@@ rtl/canny_nonmax_suppression.sv @@
// top level: canny non-maximum suppression over a raster gradient stream
//  channel   dir  tdata / payload                                 tuser
//  s_axis    in   [11:0] grad_x, [23:12] grad_y                    command
//  m_axis    out  [11:0] edge_magnitude, [13:12] direction_sector  -   (tlast frame_last)
//  cfg       in   index 0 image_width, 1 image_height
// a flush or non-emitting pixel is taken by the back part in its idle state; an emitting one
// passes through accept, three memory reads, compare, the bit-serial square root
// and the result hand-off
// reset clears counters and sets 640 x 480; line stores start undefined
// the front part and queue keep taking beats while the back part works or m_axis stalls, until the queue is full
module canny_nonmax_suppression #(
	parameter int MAX_WIDTH = cnms_pkg::MAX_WIDTH_DEF,
	parameter int GRAD_BITS = cnms_pkg::GRAD_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [2*GRAD_BITS-1:0] s_axis_tdata, // grad_x, grad_y
	input logic s_axis_tuser, // command
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [15:0] m_axis_tdata, // edge_magnitude, direction_sector, zeros
	output logic m_axis_tlast, // frame_last
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [15:0] cfg_data
);
	localparam int MAG_BITS = 2 * GRAD_BITS + 1;
	localparam int QW = 1 + MAG_BITS + 2;
	logic f_valid, f_ready, f_cmd;
	logic [MAG_BITS-1:0] f_mag;
	cnms_pkg::sector_t f_sec, b_sec, o_sec;
	logic q_valid, q_ready;
	logic [QW-1:0] q_data;
	logic [cnms_pkg::MAG_OUT_BITS-1:0] o_mag;

	assign cfg_ready = 1'b1;

	cnms_front #(.GRAD_BITS(GRAD_BITS), .MAG_BITS(MAG_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(s_axis_tuser),
		.in_gx(s_axis_tdata[GRAD_BITS-1:0]), .in_gy(s_axis_tdata[2*GRAD_BITS-1:GRAD_BITS]),
		.out_valid(f_valid), .out_ready(f_ready), .out_cmd(f_cmd), .out_mag(f_mag),
		.out_sec(f_sec)
	);

	cnms_queue #(.DW(QW)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready), .in_data({f_cmd, f_mag, f_sec}),
		.out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
	);

	assign b_sec = cnms_pkg::sector_t'(q_data[1:0]);

	cnms_back #(.MAX_WIDTH(MAX_WIDTH), .MAG_BITS(MAG_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr(cfg_valid), .cfg_idx(cfg_index), .cfg_data(cfg_data),
		.in_valid(q_valid), .in_ready(q_ready), .in_cmd(q_data[QW-1]),
		.in_mag(q_data[QW-2:2]), .in_sec(b_sec),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_mag(o_mag),
		.out_sec(o_sec), .out_last(m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, o_sec, o_mag};
endmodule
